// File: src/mvat_pkg.sv
// Shared types, constants and datapath command codes of the motion velocity
// and acceleration tracker. No dependencies.
package mvat_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DT_FRAC   = 20;
  localparam int unsigned VW        = 56;  // working vector component width
  localparam int unsigned SW        = 49;  // acceleration sample width
  localparam int unsigned DW        = 34;  // difference width

  localparam logic [23:0] DT_MIN     = 24'd105;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;
  localparam logic [63:0] VEL_EPS_SQ = 64'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);
  localparam logic [63:0] TINY_SQ    = 64'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000);

  localparam logic REG_MAX_SPEED   = 1'b0;
  localparam logic REG_SMOOTH_GAIN = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_GSQ_MUL, CMD_SQ_ADD, CMD_VEC_GV, CMD_VEC_ZERO,
    CMD_PDIFF, CMD_DIV_DT, CMD_PQ_WR, CMD_LMAG, CMD_LSHIFT, CMD_LSQ_MUL,
    CMD_MAXSQ, CMD_SQRT_START, CMD_LR_MUL, CMD_DIV_RS, CMD_RQ_WR, CMD_SEED,
    CMD_BLV_A, CMD_BLV_B, CMD_BLV_S, CMD_VDIFF, CMD_VQ_WR, CMD_BLA_A,
    CMD_BLA_B, CMD_BLA_S, CMD_SAWR, CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    logic [1:0] idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic gsq_big;
    logic primed;
    logic fits;
    logic rescale;
    logic sqrt_done;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic [23:0]        frame_time;
    logic signed [31:0] given_vel_z;
    logic signed [31:0] given_vel_y;
    logic signed [31:0] given_vel_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] acc_z;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
  } out_item_t;

endpackage

// File: src/mvat_div.sv
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on mvat_pkg.
module mvat_div
  import mvat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [63:0] quot_o,
  output logic        done_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, dvs_q;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[63]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// File: src/mvat_sqrt.sv
// Iterative floor integer square root of a 64-bit value, two radicand bits a cycle.
// Depends on mvat_pkg.
module mvat_sqrt
  import mvat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d, res_q, res_d, bit_q, bit_d;
  logic [64:0] trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = x_i;
      res_d  = '0;
      bit_d  = 64'd1 << 62;
    end else if (busy_q) begin
      if ({1'b0, x_q} >= trial) begin
        x_d   = 64'({1'b0, x_q} - trial);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign root_o = res_q[31:0];
  assign done_o = done_q;

endmodule

// File: src/mvat_dp.sv
// Datapath of the tracker: tracking state, configuration, multipliers and
// working registers. Depends on mvat_pkg, mvat_div and mvat_sqrt.
module mvat_dp
  import mvat_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  in_item_t  in_item_i,
  input  dp_ctrl_t  ctrl_i,
  output dp_stat_t  stat_o,
  output out_item_t out_item_o,
  output logic      out_first_o
);

  logic [30:0] maxs_q;
  logic [16:0] gain_q, g, gm;
  logic        primed_q, kflag_q, first_q;
  logic signed [31:0] pos_q [3], gv_q [3], last_q [3], sv_q [3], sa_q [3];
  logic [23:0] dt_q;
  logic signed [VW-1:0] vec_q [3];
  logic [VW-1:0] m_q [3];
  logic [63:0] sq_q, uprod_q, uprod_d;
  logic [31:0] ua, ub, gv_abs;
  logic signed [66:0] pa_q, pb_q, sprod;
  logic signed [48:0] sa_op;
  logic signed [17:0] sb_op;
  logic signed [67:0] bsum;
  logic signed [VW-1:0] bres, bl_q, qs, qmag;
  logic signed [DW-1:0] diff_q;
  logic [DW-1:0] diff_abs;
  logic signed [SW-1:0] smp_q;
  logic [63:0] div_dividend, div_quot;
  logic [31:0] div_divisor, root;
  logic        div_done, sqrt_done, qneg;
  out_item_t   out_q;
  logic [1:0]  idx;

  assign idx = ctrl_i.idx;
  assign g   = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
  assign gm  = GAIN_ONE - g;

  assign gv_abs   = gv_q[idx][31] ? 32'(-gv_q[idx]) : 32'(gv_q[idx]);
  assign diff_abs = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);

  // unsigned 32x32 multiplier
  always_comb begin
    ua = '0;
    ub = '0;
    unique case (ctrl_i.cmd)
      CMD_GSQ_MUL: begin ua = gv_abs; ub = gv_abs; end
      CMD_LSQ_MUL: begin ua = m_q[idx][31:0]; ub = m_q[idx][31:0]; end
      CMD_MAXSQ:   begin ua = {1'b0, maxs_q}; ub = {1'b0, maxs_q}; end
      CMD_LR_MUL:  begin ua = m_q[idx][31:0]; ub = {1'b0, maxs_q}; end
      default: ;
    endcase
  end
  assign uprod_d = ua * ub;

  // signed blend multiplier
  always_comb begin
    sa_op = '0;
    sb_op = '0;
    unique case (ctrl_i.cmd)
      CMD_BLV_A: begin sa_op = 49'(sv_q[idx]);      sb_op = {1'b0, gm}; end
      CMD_BLV_B: begin sa_op = vec_q[idx][48:0];    sb_op = {1'b0, g};  end
      CMD_BLA_A: begin sa_op = 49'(sa_q[idx]);      sb_op = {1'b0, gm}; end
      CMD_BLA_B: begin sa_op = smp_q;               sb_op = {1'b0, g};  end
      default: ;
    endcase
  end
  assign sprod = sa_op * sb_op;

  // round half up, then floor shift
  assign bsum = 68'(pa_q) + 68'(pb_q) + 68'sd32768;
  assign bres = VW'(bsum >>> 16);

  assign div_dividend = (ctrl_i.cmd == CMD_DIV_RS) ? uprod_q
                                                   : 64'({diff_abs, DT_FRAC'(0)});
  assign div_divisor  = (ctrl_i.cmd == CMD_DIV_RS) ? root : 32'(dt_q);

  mvat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.cmd == CMD_DIV_DT || ctrl_i.cmd == CMD_DIV_RS),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  mvat_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.cmd == CMD_SQRT_START),
    .x_i     (sq_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  assign qneg = (ctrl_i.cmd == CMD_RQ_WR) ? vec_q[idx][VW-1] : diff_q[DW-1];
  assign qmag = div_quot[VW-1:0];
  assign qs   = qneg ? -qmag : qmag;

  // tracking state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxs_q   <= 31'h7FFFFFFF;
      gain_q   <= 17'd32768;
      primed_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        last_q[i] <= '0;
        sv_q[i]   <= '0;
        sa_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAX_SPEED:   maxs_q <= cfg_data_i;
          REG_SMOOTH_GAIN: gain_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      unique case (ctrl_i.cmd)
        CMD_SEED: begin
          for (int i = 0; i < 3; i++) begin
            sv_q[i] <= vec_q[i][31:0];
            sa_q[i] <= '0;
          end
        end
        CMD_VQ_WR: sv_q[idx] <= bl_q[31:0];
        CMD_SAWR: begin
          for (int i = 0; i < 3; i++) sa_q[i] <= vec_q[i][31:0];
        end
        CMD_FINISH: begin
          primed_q <= 1'b1;
          for (int i = 0; i < 3; i++) last_q[i] <= pos_q[i];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_LOAD: begin
        pos_q[0] <= in_item_i.pos_x;
        pos_q[1] <= in_item_i.pos_y;
        pos_q[2] <= in_item_i.pos_z;
        gv_q[0]  <= in_item_i.given_vel_x;
        gv_q[1]  <= in_item_i.given_vel_y;
        gv_q[2]  <= in_item_i.given_vel_z;
        dt_q     <= (in_item_i.frame_time < DT_MIN) ? DT_MIN : in_item_i.frame_time;
        sq_q     <= '0;
      end
      CMD_GSQ_MUL, CMD_LSQ_MUL, CMD_MAXSQ, CMD_LR_MUL: uprod_q <= uprod_d;
      CMD_SQ_ADD: sq_q <= sq_q + uprod_q;
      CMD_VEC_GV: begin
        for (int i = 0; i < 3; i++) vec_q[i] <= VW'(gv_q[i]);
      end
      CMD_VEC_ZERO: begin
        for (int i = 0; i < 3; i++) vec_q[i] <= '0;
      end
      CMD_PDIFF: diff_q <= DW'(pos_q[idx]) - DW'(last_q[idx]);
      CMD_PQ_WR: vec_q[idx] <= qs;
      CMD_LMAG: begin
        for (int i = 0; i < 3; i++) m_q[i] <= vec_q[i][VW-1] ? VW'(-vec_q[i]) : VW'(vec_q[i]);
        kflag_q <= 1'b0;
        sq_q    <= '0;
      end
      CMD_LSHIFT: begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        kflag_q <= 1'b1;
      end
      CMD_RQ_WR: vec_q[idx] <= (root == '0) ? '0 : qs;
      CMD_BLV_A, CMD_BLA_A: pa_q <= sprod;
      CMD_BLV_B, CMD_BLA_B: pb_q <= sprod;
      CMD_BLV_S: bl_q <= bres;
      CMD_VDIFF: diff_q <= bl_q[DW-1:0] - DW'(sv_q[idx]);
      CMD_VQ_WR: smp_q <= qs[SW-1:0];
      CMD_BLA_S: vec_q[idx] <= bres;
      CMD_FINISH: begin
        out_q.vel_x <= sv_q[0];
        out_q.vel_y <= sv_q[1];
        out_q.vel_z <= sv_q[2];
        out_q.acc_x <= sa_q[0];
        out_q.acc_y <= sa_q[1];
        out_q.acc_z <= sa_q[2];
        first_q     <= ~primed_q;
      end
      default: ;
    endcase
  end

  assign stat_o.gsq_big   = sq_q > VEL_EPS_SQ;
  assign stat_o.primed    = primed_q;
  assign stat_o.fits      = ~(|m_q[0][VW-1:31]) & ~(|m_q[1][VW-1:31]) & ~(|m_q[2][VW-1:31]);
  assign stat_o.rescale   = kflag_q | ((sq_q > uprod_q) & (sq_q > TINY_SQ));
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.div_done  = div_done;

  assign out_item_o  = out_q;
  assign out_first_o = first_q;

endmodule

// File: src/mvat_ctrl.sv
// Sequencing state machine of the tracker: steps the datapath through one
// transaction and runs both handshakes. Depends on mvat_pkg.
module mvat_ctrl
  import mvat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_ctrl_t ctrl_o
);

  typedef enum logic [29:0] {
    S_IDLE        = 30'h00000001, S_GSQ_MUL     = 30'h00000002,
    S_GSQ_ADD     = 30'h00000004, S_GSQ_TEST    = 30'h00000008,
    S_PDIFF       = 30'h00000010, S_PDIV_START  = 30'h00000020,
    S_PDIV_WAIT   = 30'h00000040, S_LMAG        = 30'h00000080,
    S_LSHIFT      = 30'h00000100, S_LSQ_MUL     = 30'h00000200,
    S_LSQ_ADD     = 30'h00000400, S_LMAXSQ      = 30'h00000800,
    S_LDECIDE     = 30'h00001000, S_LSQRT_START = 30'h00002000,
    S_LSQRT_WAIT  = 30'h00004000, S_LR_MUL      = 30'h00008000,
    S_LR_START    = 30'h00010000, S_LR_WAIT     = 30'h00020000,
    S_SEED        = 30'h00040000, S_BV_A        = 30'h00080000,
    S_BV_B        = 30'h00100000, S_BV_S        = 30'h00200000,
    S_VDIFF       = 30'h00400000, S_VDIV_START  = 30'h00800000,
    S_VDIV_WAIT   = 30'h01000000, S_BA_A        = 30'h02000000,
    S_BA_B        = 30'h04000000, S_BA_S        = 30'h08000000,
    S_SAWR        = 30'h10000000, S_FINISH      = 30'h20000000
  } state_e;

  state_e     state_q, state_d, lim_next;
  logic [1:0] idx_q, idx_d;
  logic       pass_q, pass_d, ovalid_q, ovalid_d;
  dp_cmd_e    cmd;
  logic       last_idx;

  assign last_idx = (idx_q == 2'd2);
  assign lim_next = pass_q ? S_SAWR : (stat_i.primed ? S_BV_A : S_SEED);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pass_d   = pass_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    cmd      = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd     = CMD_LOAD;
          idx_d   = '0;
          pass_d  = 1'b0;
          state_d = S_GSQ_MUL;
        end
      end
      S_GSQ_MUL: begin cmd = CMD_GSQ_MUL; state_d = S_GSQ_ADD; end
      S_GSQ_ADD: begin
        cmd     = CMD_SQ_ADD;
        idx_d   = last_idx ? 2'd0 : idx_q + 2'd1;
        state_d = last_idx ? S_GSQ_TEST : S_GSQ_MUL;
      end
      S_GSQ_TEST: begin
        priority if (stat_i.gsq_big) begin
          cmd     = CMD_VEC_GV;
          state_d = S_LMAG;
        end else if (stat_i.primed) begin
          state_d = S_PDIFF;
        end else begin
          cmd     = CMD_VEC_ZERO;
          state_d = S_SEED;
        end
      end
      S_PDIFF:      begin cmd = CMD_PDIFF;  state_d = S_PDIV_START; end
      S_PDIV_START: begin cmd = CMD_DIV_DT; state_d = S_PDIV_WAIT;  end
      S_PDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd     = CMD_PQ_WR;
          idx_d   = last_idx ? 2'd0 : idx_q + 2'd1;
          state_d = last_idx ? S_LMAG : S_PDIFF;
        end
      end
      S_LMAG: begin cmd = CMD_LMAG; state_d = S_LSHIFT; end
      S_LSHIFT: begin
        if (stat_i.fits) begin
          idx_d   = '0;
          state_d = S_LSQ_MUL;
        end else begin
          cmd = CMD_LSHIFT;
        end
      end
      S_LSQ_MUL: begin cmd = CMD_LSQ_MUL; state_d = S_LSQ_ADD; end
      S_LSQ_ADD: begin
        cmd     = CMD_SQ_ADD;
        idx_d   = last_idx ? 2'd0 : idx_q + 2'd1;
        state_d = last_idx ? S_LMAXSQ : S_LSQ_MUL;
      end
      S_LMAXSQ:  begin cmd = CMD_MAXSQ; state_d = S_LDECIDE; end
      S_LDECIDE: begin
        idx_d   = '0;
        state_d = stat_i.rescale ? S_LSQRT_START : lim_next;
      end
      S_LSQRT_START: begin cmd = CMD_SQRT_START; state_d = S_LSQRT_WAIT; end
      S_LSQRT_WAIT:  begin if (stat_i.sqrt_done) state_d = S_LR_MUL; end
      S_LR_MUL:   begin cmd = CMD_LR_MUL; state_d = S_LR_START; end
      S_LR_START: begin cmd = CMD_DIV_RS; state_d = S_LR_WAIT;  end
      S_LR_WAIT: begin
        if (stat_i.div_done) begin
          cmd     = CMD_RQ_WR;
          idx_d   = last_idx ? 2'd0 : idx_q + 2'd1;
          state_d = last_idx ? lim_next : S_LR_MUL;
        end
      end
      S_SEED:       begin cmd = CMD_SEED;   state_d = S_FINISH;     end
      S_BV_A:       begin cmd = CMD_BLV_A;  state_d = S_BV_B;       end
      S_BV_B:       begin cmd = CMD_BLV_B;  state_d = S_BV_S;       end
      S_BV_S:       begin cmd = CMD_BLV_S;  state_d = S_VDIFF;      end
      S_VDIFF:      begin cmd = CMD_VDIFF;  state_d = S_VDIV_START; end
      S_VDIV_START: begin cmd = CMD_DIV_DT; state_d = S_VDIV_WAIT;  end
      S_VDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd     = CMD_VQ_WR;
          state_d = S_BA_A;
        end
      end
      S_BA_A: begin cmd = CMD_BLA_A; state_d = S_BA_B; end
      S_BA_B: begin cmd = CMD_BLA_B; state_d = S_BA_S; end
      S_BA_S: begin
        cmd     = CMD_BLA_S;
        idx_d   = last_idx ? 2'd0 : idx_q + 2'd1;
        pass_d  = last_idx;
        state_d = last_idx ? S_LMAG : S_BV_A;
      end
      S_SAWR: begin cmd = CMD_SAWR; state_d = S_FINISH; end
      S_FINISH: begin
        // hold until the output register is free
        if (!ovalid_q || out_ready_i) begin
          cmd      = CMD_FINISH;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      pass_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pass_q   <= pass_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign ctrl_o.cmd  = cmd;
  assign ctrl_o.idx  = idx_q;

endmodule

// File: src/motion_velocity_accel_tracker_top.sv
// Top level of the motion velocity and acceleration tracker.
// Depends on mvat_pkg, mvat_ctrl and mvat_dp (with mvat_div and mvat_sqrt).
//
// Tracks an observer's velocity and acceleration from a stream of position
// samples in Q16.16. Each input transaction carries a position, an optional
// supplied velocity (used when longer than 1e-3, otherwise the velocity is the
// position difference over the frame time) and a frame time in Q4.20 seconds,
// raised to a floor of 105. Velocity and acceleration are blended with
// smoothing_gain and limited in length to max_speed; the first transaction
// after reset seeds the tracker and reports was_first. One input transaction
// gives exactly one output transaction. Items are processed one at a time:
// an item uses the shared serial divider for up to twelve divisions and the
// square root unit up to twice. A finished result waits in the output
// register while the next input transaction is taken. Write configuration
// only while the block is idle.
module motion_velocity_accel_tracker_top
  import mvat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port: index 0 max_speed, index 1 smoothing_gain
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [30:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: pos_x, pos_y, pos_z, given_vel_x, given_vel_y,
  // given_vel_z (32 bits each), frame_time (24 bits)
  input  logic [215:0] s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: vel_x, vel_y, vel_z, acc_x, acc_y, acc_z (32 bits each)
  output logic [191:0] m_axis_tdata,
  // tuser: was_first
  output logic [0:0]   m_axis_tuser
);

  dp_ctrl_t  ctrl;
  dp_stat_t  stat;
  out_item_t out_item;
  logic      out_first;

  mvat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mvat_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_t'(s_axis_tdata)),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_item_o  (out_item),
    .out_first_o (out_first)
  );

  assign m_axis_tdata = out_item;
  assign m_axis_tuser = out_first;

endmodule
